// ===== rtl/sipt_pkg.sv =====
// shared widths, constants and register codes of the sphere inversion unit
package sipt_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CW     = 32;
    localparam int RADW   = 31;
    localparam int OTW    = 18;
    localparam int CFG_IW = 2;

    localparam int L2W  = 64;
    localparam int LENW = 32;

    localparam logic [RADW-1:0] RADIUS_RST = RADW'(131072);

    localparam logic [CFG_IW-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_RADIUS   = 2'd3;

endpackage

// ===== rtl/sipt_dly.sv =====
// stall-aware delay line for sideband data
module sipt_dly #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[D-1];

endmodule

// ===== rtl/sipt_pdiv.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module sipt_pdiv #(
    parameter int NW = 95,
    parameter int DW = 66,
    parameter int QW = 41
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic [RW-1:0] w_rem [QW];
    logic [DW-1:0] w_den [QW];
    logic [QW-1:0] w_quo [QW];
    logic          w_ovf [QW];

    logic [RW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];
    logic          r_ovf [QW];

    for (genvar j = 0; j < QW; j++) begin : g_st
        logic [RW-1:0] w_sub;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem[j] = RW'(i_num);
            assign w_den[j] = i_den;
            assign w_quo[j] = '0;
            assign w_ovf[j] = RW'(i_num) >= (RW'(i_den) << QW);
        end else begin : g_next
            assign w_rem[j] = r_rem[j-1];
            assign w_den[j] = r_den[j-1];
            assign w_quo[j] = r_quo[j-1];
            assign w_ovf[j] = r_ovf[j-1];
        end

        assign w_sub = RW'(w_den[j]) << (QW - 1 - j);
        assign w_ge  = w_rem[j] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= w_quo[j] | (w_ge ? (QW'(1) << (QW - 1 - j)) : '0);
                r_ovf[j] <= w_ovf[j];
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? w_rem[j] - w_sub : w_rem[j];
                    r_den[j] <= w_den[j];
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule

// ===== rtl/sipt_isqrt.sv =====
// pipelined floor integer square root, one result bit per stage
module sipt_isqrt (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [sipt_pkg::L2W-1:0] i_x,
    output logic [sipt_pkg::LENW-1:0] o_root
);

    import sipt_pkg::*;

    localparam int N = L2W / 2;

    logic [L2W-1:0] w_x   [N];
    logic [L2W-1:0] w_res [N];
    logic [L2W-1:0] r_x   [N-1];
    logic [L2W-1:0] r_res [N];

    for (genvar j = 0; j < N; j++) begin : g_st
        logic [L2W-1:0] w_bit;
        logic [L2W-1:0] w_try;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_x[j]   = i_x;
            assign w_res[j] = '0;
        end else begin : g_next
            assign w_x[j]   = r_x[j-1];
            assign w_res[j] = r_res[j-1];
        end

        assign w_bit = L2W'(1) << (L2W - 2 - 2 * j);
        assign w_try = w_res[j] + w_bit;
        assign w_ge  = w_x[j] >= w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[j] <= w_ge ? (w_res[j] >> 1) + w_bit : w_res[j] >> 1;
            end
        end

        if (j < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j] <= w_ge ? w_x[j] - w_try : w_x[j];
                end
            end
        end
    end

    assign o_root = r_res[N-1][LENW-1:0];

endmodule

// ===== rtl/sphere_inversion_point_tangent_unit.sv =====
// Sphere inversion of a curve node: point (Q15.16), unit tangent (Q1.16). Takes one
// node per clock unless stalled and returns one result per node, in order; the
// depth is set by the tangent path: thirteen stages of products and normalising,
// the 32-stage square root, the FRAC_BITS + 2 stage tangent divider and its
// rounding and output registers run in series, while the 41-stage point divider
// runs alongside. A stall on a waiting result freezes the whole pipeline and is
// passed back combinationally to o_in_stall. Configuration writes take effect at
// once and are to be made only while no node is in flight.
module sphere_inversion_point_tangent_unit #(
    parameter int FRAC_BITS = sipt_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sipt_pkg::CW-1:0]     i_point_x,
    input  logic [sipt_pkg::CW-1:0]     i_point_y,
    input  logic [sipt_pkg::CW-1:0]     i_point_z,
    input  logic [sipt_pkg::CW-1:0]     i_tangent_x,
    input  logic [sipt_pkg::CW-1:0]     i_tangent_y,
    input  logic [sipt_pkg::CW-1:0]     i_tangent_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sipt_pkg::CW-1:0]     o_new_point_x,
    output logic [sipt_pkg::CW-1:0]     o_new_point_y,
    output logic [sipt_pkg::CW-1:0]     o_new_point_z,
    output logic [sipt_pkg::OTW-1:0]    o_new_tangent_x,
    output logic [sipt_pkg::OTW-1:0]    o_new_tangent_y,
    output logic [sipt_pkg::OTW-1:0]    o_new_tangent_z,
    output logic                        o_degenerate,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sipt_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [sipt_pkg::CW-1:0]     i_cfg_data
);

    import sipt_pkg::*;

    localparam int VW       = CW + 1;
    localparam int RRW      = 2 * RADW;
    localparam int SQW      = 2 * CW + 2;
    localparam int PNW      = CW + RRW + 1;
    localparam int PQW      = 41;
    localparam int QCAP_EXP = 40;
    localparam int PSW      = PQW + 2;
    localparam int VLIM_EXP = 20;
    localparam int SHW      = 4;
    localparam int SVW      = VLIM_EXP + 1;
    localparam int PW       = 2 * SVW;
    localparam int NSW      = PW + 2;
    localparam int WW       = 66;
    localparam int MAGW     = 64;
    localparam int BLW      = 7;
    localparam int MW       = 31;
    localparam int MSQW     = 2 * MW;
    localparam int TNW      = FRAC_BITS + 32;
    localparam int TQW      = FRAC_BITS + 2;
    localparam int PFIN     = 47;
    localparam int LO       = FRAC_BITS + 49;

    localparam logic [PQW-1:0] PQCAP = PQW'(1) << QCAP_EXP;
    localparam logic [TQW-1:0] TQCAP = TQW'(1) << FRAC_BITS;
    localparam logic [CW-1:0]  SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]  SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic [BLW-1:0] bit_len(input logic [MAGW-1:0] x);
        logic [BLW-1:0] n;
        n = '0;
        for (int k = 0; k < MAGW; k++) begin
            if (x[k]) begin
                n = BLW'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [SHW-1:0] pre_shift(input logic [CW-1:0] x);
        logic [BLW-1:0] n;
        n = bit_len(MAGW'(x));
        return (n > BLW'(VLIM_EXP)) ? SHW'(n - BLW'(VLIM_EXP)) : '0;
    endfunction

    function automatic logic [MAGW-1:0] max3(input logic [MAGW-1:0] a, input logic [MAGW-1:0] b,
                                             input logic [MAGW-1:0] c);
        logic [MAGW-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    // configuration registers
    logic [CW-1:0]   r_center_x, r_center_y, r_center_z;
    logic [RADW-1:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_CENTER_Z: r_center_z <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[RADW-1:0];
            endcase
        end
    end

    // pipeline control
    logic          en;
    logic [LO:1]   r_vld;

    assign en          = !r_vld[LO] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LO-1:1], i_in_valid};
        end
    end

    logic signed [CW-1:0] w_p [3];
    logic signed [CW-1:0] w_t [3];
    logic signed [CW-1:0] w_c [3];

    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;
    assign w_t[0] = i_tangent_x;
    assign w_t[1] = i_tangent_y;
    assign w_t[2] = i_tangent_z;
    assign w_c[0] = r_center_x;
    assign w_c[1] = r_center_y;
    assign w_c[2] = r_center_z;

    // stage 1: offset from centre, radius squared
    logic signed [VW-1:0] r1_v [3];
    logic signed [CW-1:0] r1_t [3];
    logic [RRW-1:0]       r1_rr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= VW'(w_p[i]) - VW'(w_c[i]);
                r1_t[i] <= w_t[i];
            end
            r1_rr <= RRW'(r_radius) * RRW'(r_radius);
        end
    end

    // stage 2: magnitudes and signs
    logic [CW-1:0]  r2_av [3];
    logic [CW-1:0]  r2_mt [3];
    logic [2:0]     r2_vneg, r2_tneg;
    logic [RRW-1:0] r2_rr;
    logic           r2_rrz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_av[i]   <= r1_v[i][VW-1] ? CW'(-r1_v[i]) : CW'(r1_v[i]);
                r2_mt[i]   <= r1_t[i][CW-1] ? CW'(-(VW'(r1_t[i]))) : CW'(r1_t[i]);
                r2_vneg[i] <= r1_v[i][VW-1];
                r2_tneg[i] <= r1_t[i][CW-1];
            end
            r2_rr  <= r1_rr;
            r2_rrz <= (r1_rr == '0);
        end
    end

    // stage 3: squares, partial products, maxima
    logic [2*CW-1:0]    r3_sq  [3];
    logic [CW+RADW-1:0] r3_prl [3];
    logic [CW+RADW-1:0] r3_prh [3];
    logic [CW-1:0]      r3_av  [3];
    logic [CW-1:0]      r3_mt  [3];
    logic [CW-1:0]      r3_mxv, r3_mxt;
    logic [2:0]         r3_vneg, r3_tneg;
    logic               r3_rrz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i]  <= (2*CW)'(r2_av[i]) * (2*CW)'(r2_av[i]);
                r3_prl[i] <= (CW+RADW)'(r2_av[i]) * (CW+RADW)'(r2_rr[RADW-1:0]);
                r3_prh[i] <= (CW+RADW)'(r2_av[i]) * (CW+RADW)'(r2_rr[RRW-1:RADW]);
                r3_av[i]  <= r2_av[i];
                r3_mt[i]  <= r2_mt[i];
            end
            r3_mxv  <= CW'(max3(MAGW'(r2_av[0]), MAGW'(r2_av[1]), MAGW'(r2_av[2])));
            r3_mxt  <= CW'(max3(MAGW'(r2_mt[0]), MAGW'(r2_mt[1]), MAGW'(r2_mt[2])));
            r3_vneg <= r2_vneg;
            r3_tneg <= r2_tneg;
            r3_rrz  <= r2_rrz;
        end
    end

    // stage 4: squared length, numerators, prescale shifts
    logic [SQW-1:0] r4_n2;
    logic [PNW-1:0] r4_num0 [3];
    logic [CW-1:0]  r4_av   [3];
    logic [CW-1:0]  r4_mt   [3];
    logic [SHW-1:0] r4_sv, r4_st;
    logic [2:0]     r4_vneg, r4_tneg;
    logic           r4_rrz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_n2 <= SQW'(r3_sq[0]) + SQW'(r3_sq[1]) + SQW'(r3_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r4_num0[i] <= PNW'(r3_prl[i]) + (PNW'(r3_prh[i]) << RADW);
                r4_av[i]   <= r3_av[i];
                r4_mt[i]   <= r3_mt[i];
            end
            r4_sv   <= pre_shift(r3_mxv);
            r4_st   <= pre_shift(r3_mxt);
            r4_vneg <= r3_vneg;
            r4_tneg <= r3_tneg;
            r4_rrz  <= r3_rrz;
        end
    end

    // stage 5: rounded numerators, prescaled vectors
    logic [PNW-1:0]        r5_num [3];
    logic [SQW-1:0]        r5_n2;
    logic                  r5_n2z, r5_rrz;
    logic [2:0]            r5_vneg;
    logic signed [SVW-1:0] r5_vs [3];
    logic signed [SVW-1:0] r5_ts [3];
    logic signed [SVW-1:0] w5_vm [3];
    logic signed [SVW-1:0] w5_tm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w5_vm[i] = $signed(SVW'(r4_av[i] >> r4_sv));
            w5_tm[i] = $signed(SVW'(r4_mt[i] >> r4_st));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_num[i] <= r4_num0[i] + PNW'(r4_n2 >> 1);
                r5_vs[i]  <= r4_vneg[i] ? -w5_vm[i] : w5_vm[i];
                r5_ts[i]  <= r4_tneg[i] ? -w5_tm[i] : w5_tm[i];
            end
            r5_n2   <= r4_n2;
            r5_n2z  <= (r4_n2 == '0);
            r5_rrz  <= r4_rrz;
            r5_vneg <= r4_vneg;
        end
    end

    // point division
    logic [PQW-1:0] w46_q [3];
    logic [2:0]     w46_ovf;
    logic [4:0]     w46_side;

    for (genvar g = 0; g < 3; g++) begin : g_pdiv
        sipt_pdiv #(
            .NW(PNW),
            .DW(SQW),
            .QW(PQW)
        ) u_pdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r5_num[g]),
            .i_den (r5_n2),
            .o_quo (w46_q[g]),
            .o_ovf (w46_ovf[g])
        );
    end

    sipt_dly #(
        .W(5),
        .D(PQW)
    ) u_pside (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r5_vneg, r5_n2z, r5_rrz}),
        .o_q   (w46_side)
    );

    // point final: cap, sign, add centre, saturate; a zero offset gives the maximum
    logic [PQW-1:0]       w47_qc [3];
    logic signed [PSW-1:0] w47_d  [3];
    logic signed [PSW-1:0] w47_s  [3];
    logic [CW-1:0]        r47_np [3];
    logic                 r47_n2z, r47_rrz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w47_qc[i] = (w46_ovf[i] || w46_q[i] > PQCAP) ? PQCAP : w46_q[i];
            w47_d[i]  = w46_side[2+i] ? -$signed({2'b00, w47_qc[i]})
                                      : $signed({2'b00, w47_qc[i]});
            w47_s[i]  = PSW'(w_c[i]) + w47_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (w46_side[1]) begin
                    r47_np[i] <= SAT_MAX;
                end else if (w47_s[i][PSW-1:CW-1] == '0 || w47_s[i][PSW-1:CW-1] == '1) begin
                    r47_np[i] <= w47_s[i][CW-1:0];
                end else begin
                    r47_np[i] <= w47_s[i][PSW-1] ? SAT_MIN : SAT_MAX;
                end
            end
            r47_n2z <= w46_side[1];
            r47_rrz <= w46_side[0];
        end
    end

    logic [3*CW+1:0] w_pout;

    sipt_dly #(
        .W(3*CW+2),
        .D(LO-PFIN)
    ) u_pout (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r47_np[2], r47_np[1], r47_np[0], r47_n2z, r47_rrz}),
        .o_q   (w_pout)
    );

    // stage 6: products of prescaled vectors
    logic signed [PW-1:0]  r6_vv [3];
    logic signed [PW-1:0]  r6_tv [3];
    logic signed [SVW-1:0] r6_vs [3];
    logic signed [SVW-1:0] r6_ts [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_vv[i] <= PW'(r5_vs[i]) * PW'(r5_vs[i]);
                r6_tv[i] <= PW'(r5_ts[i]) * PW'(r5_vs[i]);
                r6_vs[i] <= r5_vs[i];
                r6_ts[i] <= r5_ts[i];
            end
        end
    end

    // stage 7: squared length and dot product
    logic signed [NSW-1:0] r7_n2, r7_dot;
    logic signed [SVW-1:0] r7_vs [3];
    logic signed [SVW-1:0] r7_ts [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_n2  <= NSW'(r6_vv[0]) + NSW'(r6_vv[1]) + NSW'(r6_vv[2]);
            r7_dot <= NSW'(r6_tv[0]) + NSW'(r6_tv[1]) + NSW'(r6_tv[2]);
            for (int i = 0; i < 3; i++) begin
                r7_vs[i] <= r6_vs[i];
                r7_ts[i] <= r6_ts[i];
            end
        end
    end

    // stage 8: jacobian terms
    logic signed [WW-1:0] r8_a [3];
    logic signed [WW-1:0] r8_b [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_a[i] <= WW'(r7_n2) * WW'(r7_ts[i]);
                r8_b[i] <= WW'(r7_vs[i]) * WW'(r7_dot);
            end
        end
    end

    // stage 9: mapped direction magnitude and sign
    logic signed [WW-1:0] w9_w [3];
    logic [MAGW-1:0]      r9_m [3];
    logic [2:0]           r9_wneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w9_w[i] = r8_a[i] - (r8_b[i] <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r9_m[i]    <= w9_w[i][WW-1] ? MAGW'(-w9_w[i]) : MAGW'(w9_w[i]);
                r9_wneg[i] <= w9_w[i][WW-1];
            end
        end
    end

    // stage 10: leading bit of the largest component
    logic [MAGW-1:0] r10_m [3];
    logic [BLW-1:0]  r10_bl;
    logic [2:0]      r10_wneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_bl   <= bit_len(max3(r9_m[0], r9_m[1], r9_m[2]));
            r10_m    <= r9_m;
            r10_wneg <= r9_wneg;
        end
    end

    // stage 11: normalise so the largest lies in [2^30, 2^31)
    logic [MW-1:0] r11_mn [3];
    logic [2:0]    r11_wneg;
    logic          r11_mxz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (r10_bl > BLW'(MW)) begin
                    r11_mn[i] <= MW'(r10_m[i] >> (r10_bl - BLW'(MW)));
                end else begin
                    r11_mn[i] <= MW'(r10_m[i] << (BLW'(MW) - r10_bl));
                end
            end
            r11_wneg <= r10_wneg;
            r11_mxz  <= (r10_bl == '0);
        end
    end

    // stage 12: component squares
    logic [MSQW-1:0] r12_sq [3];
    logic [MW-1:0]   r12_mn [3];
    logic [2:0]      r12_wneg;
    logic            r12_mxz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r12_sq[i] <= MSQW'(r11_mn[i]) * MSQW'(r11_mn[i]);
            end
            r12_mn   <= r11_mn;
            r12_wneg <= r11_wneg;
            r12_mxz  <= r11_mxz;
        end
    end

    // stage 13: squared length of the normalised direction
    logic [L2W-1:0] r13_l2;
    logic [MW-1:0]  r13_mn [3];
    logic [2:0]     r13_wneg;
    logic           r13_mxz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_l2   <= L2W'(r12_sq[0]) + L2W'(r12_sq[1]) + L2W'(r12_sq[2]);
            r13_mn   <= r12_mn;
            r13_wneg <= r12_wneg;
            r13_mxz  <= r12_mxz;
        end
    end

    // length by square root
    logic [LENW-1:0]   w45_len;
    logic [3*MW+3:0]   w45_side;

    sipt_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r13_l2),
        .o_root (w45_len)
    );

    sipt_dly #(
        .W(3*MW+4),
        .D(L2W/2)
    ) u_sqside (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r13_mn[2], r13_mn[1], r13_mn[0], r13_wneg, r13_mxz}),
        .o_q   (w45_side)
    );

    // stage 46: rounded tangent numerators
    logic [TNW-1:0]  r46_tn [3];
    logic [LENW-1:0] r46_len;
    logic [2:0]      r46_wneg;
    logic            r46_mxz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r46_tn[i] <= (TNW'(w45_side[4+MW*i +: MW]) << FRAC_BITS)
                             + TNW'(w45_len >> 1);
            end
            r46_len  <= w45_len;
            r46_wneg <= w45_side[3:1];
            r46_mxz  <= w45_side[0];
        end
    end

    // tangent division
    logic [TQW-1:0] w_tq [3];
    logic [2:0]     w_tovf;
    logic [3:0]     w_tside;

    for (genvar g = 0; g < 3; g++) begin : g_tdiv
        sipt_pdiv #(
            .NW(TNW),
            .DW(LENW),
            .QW(TQW)
        ) u_tdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r46_tn[g]),
            .i_den (r46_len),
            .o_quo (w_tq[g]),
            .o_ovf (w_tovf[g])
        );
    end

    sipt_dly #(
        .W(4),
        .D(TQW)
    ) u_tside (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r46_wneg, r46_mxz}),
        .o_q   (w_tside)
    );

    // tangent final: cap at one, apply sign, zero for a null direction
    logic [TQW-1:0] w_tqc [3];
    logic [OTW-1:0] w_tmag [3];
    logic [OTW-1:0] r_nt [3];
    logic           r_tmxz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_tqc[i]  = (w_tovf[i] || w_tq[i] > TQCAP) ? TQCAP : w_tq[i];
            w_tmag[i] = OTW'(w_tqc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_tside[0]) begin
                    r_nt[i] <= '0;
                end else begin
                    r_nt[i] <= w_tside[1+i] ? -w_tmag[i] : w_tmag[i];
                end
            end
            r_tmxz <= w_tside[0];
        end
    end

    // outputs
    logic w_pflag;

    assign w_pflag = w_pout[1] | w_pout[0];

    assign o_new_point_x   = w_pout[2 +: CW];
    assign o_new_point_y   = w_pout[2+CW +: CW];
    assign o_new_point_z   = w_pout[2+2*CW +: CW];
    assign o_new_tangent_x = w_pflag ? '0 : r_nt[0];
    assign o_new_tangent_y = w_pflag ? '0 : r_nt[1];
    assign o_new_tangent_z = w_pflag ? '0 : r_nt[2];
    assign o_degenerate    = w_pflag | r_tmxz;

endmodule
